// ===== rtl/lbm_pkg.sv =====
// Shared constants, types and the pixel red gradient function for the LED bar level meter.
// Used by lbm_ctrl, lbm_dpath and the top level; depends on nothing.
`timescale 1ns / 1ps

package lbm_pkg;

	localparam int PIXEL_COUNT = 7;

	localparam int SMP_W   = 10;
	localparam int STEP_W  = 10;
	localparam int HOLD_W  = 24;
	localparam int TIMER_W = 25;
	localparam int LIT_W   = 6;
	localparam int IDX_W   = 5;
	localparam int COL_W   = 8;
	localparam int CFG_W   = 24;
	localparam int CIDX_W  = 2;
	localparam int DCNT_W  = 4;

	// Register indexes of the configuration port
	localparam logic [CIDX_W-1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_LEVEL_STEP = 2'd1;
	localparam logic [CIDX_W-1:0] REG_HOLD_TICKS = 2'd2;

	localparam logic [SMP_W-1:0]  THRESHOLD_RST  = 10'd650;
	localparam logic [STEP_W-1:0] LEVEL_STEP_RST = 10'd30;
	localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = 24'd500000;

	localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
	localparam logic [DCNT_W-1:0]  DIV_BITS  = DCNT_W'(SMP_W);
	localparam logic [LIT_W-1:0]   LIT_MAX   = LIT_W'(PIXEL_COUNT);
	localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(PIXEL_COUNT - 1);

	// Input action codes
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	localparam int RED_Q = 255 / PIXEL_COUNT;

	// Gradient red for a pixel: q*1.5*(i+1) rounded half up, clamped at 255
	function automatic logic [COL_W-1:0] red_for(input logic [IDX_W-1:0] idx);
		int v;
		begin
			v = (3 * RED_Q * (int'(idx) + 1) + 1) >> 1;
			red_for = (v > 255) ? 8'd255 : COL_W'(v);
		end
	endfunction

	typedef struct packed {
		logic tick;        // advance the hold timer, drop a pixel if expired
		logic div_start;   // load the divider with sample - threshold
		logic div_step;    // one restoring divide step
		logic apply;       // restart timer, raise the bar if the count allows
		logic emit;        // load the next pixel word into the output register
	} lbm_cmd_t;

	typedef struct packed {
		logic drop;        // a tick on the input would drop a pixel
		logic qual;        // input sample is above threshold
		logic step_zero;   // level_step register is zero
		logic div_done;    // all divide steps done
		logic rise;        // candidate count is not below the lit count
		logic idx_last;    // pixel counter is on the last pixel
		logic out_free;    // output register can take a word
	} lbm_sts_t;

endpackage

// ===== rtl/lbm_ctrl.sv =====
// Controller state machine of the LED bar level meter.
// Depends on lbm_pkg; drives lbm_dpath through lbm_cmd_t.
`timescale 1ns / 1ps

module lbm_ctrl
	import lbm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_action,
	output logic     in_ready,
	input  lbm_sts_t sts,
	output lbm_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       take;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (in_action == ACT_TICK) begin
						cmd.tick = 1'b1;
						if (sts.drop)
							state_d = ST_EMIT;
					end else if (sts.qual) begin
						if (sts.step_zero) begin
							cmd.apply = 1'b1;
							if (sts.rise)
								state_d = ST_EMIT;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = ST_DIV;
						end
					end
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.apply = 1'b1;
					state_d   = sts.rise ? ST_EMIT : ST_IDLE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.idx_last)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/lbm_dpath.sv =====
// Datapath of the LED bar level meter: config registers, divider, bar state,
// hold timer, pixel counter and output register. Depends on lbm_pkg.
`timescale 1ns / 1ps

module lbm_dpath
	import lbm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [SMP_W-1:0]  in_sample,
	input  lbm_cmd_t          cmd,
	output lbm_sts_t          sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  out_idx,
	output logic [COL_W-1:0]  out_red,
	output logic [COL_W-1:0]  out_green,
	output logic [LIT_W-1:0]  out_lit,
	output logic              out_last
);

	logic [SMP_W-1:0]   thr_q;
	logic [STEP_W-1:0]  step_q;
	logic [HOLD_W-1:0]  hold_q;
	logic [LIT_W-1:0]   lit_q;
	logic [TIMER_W-1:0] timer_q;
	logic [SMP_W-1:0]   quo_q;
	logic [STEP_W-1:0]  rem_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic               ovalid_q;

	logic [TIMER_W-1:0] timer_inc;
	logic [STEP_W:0]    trial;
	logic               trial_ok;
	logic [SMP_W:0]     quo_plus;
	logic [LIT_W-1:0]   cand;
	logic               pix_on;
	logic [COL_W-1:0]   red_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THRESHOLD_RST;
			step_q <= LEVEL_STEP_RST;
			hold_q <= HOLD_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD:  thr_q  <= cfg_data[SMP_W-1:0];
				REG_LEVEL_STEP: step_q <= cfg_data[STEP_W-1:0];
				REG_HOLD_TICKS: hold_q <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign timer_inc = (timer_q == TIMER_MAX) ? timer_q : timer_q + 1'b1;

	// Restoring divide, one quotient bit per step
	assign trial    = {rem_q, quo_q[SMP_W-1]} - {1'b0, step_q};
	assign trial_ok = !trial[STEP_W];

	// Candidate count: quotient + 2 capped at the pixel count; the pixel count when level_step is zero
	assign quo_plus = {1'b0, quo_q} + (SMP_W+1)'(2);
	always_comb begin
		if (step_q == '0 || quo_plus > (SMP_W+1)'(PIXEL_COUNT))
			cand = LIT_MAX;
		else
			cand = quo_plus[LIT_W-1:0];
	end

	assign sts.drop      = (lit_q != '0) && (timer_inc > {1'b0, hold_q});
	assign sts.qual      = in_sample > thr_q;
	assign sts.step_zero = (step_q == '0);
	assign sts.div_done  = (dcnt_q == '0);
	assign sts.rise      = (cand >= lit_q);
	assign sts.idx_last  = (idx_q == IDX_LAST);
	assign sts.out_free  = !ovalid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q    <= '0;
			timer_q  <= '0;
			dcnt_q   <= '0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.tick) begin
				if (sts.drop) begin
					lit_q   <= lit_q - 1'b1;
					timer_q <= '0;
				end else begin
					timer_q <= timer_inc;
				end
			end
			if (cmd.apply) begin
				timer_q <= '0;
				if (sts.rise)
					lit_q <= cand;
			end
			if (cmd.div_start)
				dcnt_q <= DIV_BITS;
			else if (cmd.div_step)
				dcnt_q <= dcnt_q - 1'b1;
			if (cmd.emit) begin
				idx_q    <= sts.idx_last ? '0 : idx_q + 1'b1;
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= in_sample - thr_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SMP_W-2:0], trial_ok};
			rem_q <= trial_ok ? trial[STEP_W-1:0] : {rem_q[STEP_W-2:0], quo_q[SMP_W-1]};
		end
	end

	assign pix_on  = {1'b0, idx_q} < lit_q;
	assign red_val = pix_on ? red_for(idx_q) : '0;

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_idx   <= idx_q;
			out_red   <= red_val;
			out_green <= pix_on ? 8'd255 - red_val : '0;
			out_lit   <= lit_q;
			out_last  <= sts.idx_last;
		end
	end

	assign out_valid = ovalid_q;

	a_lit_range: assert property (@(posedge clk) disable iff (!arst_n)
		lit_q <= LIT_MAX)
		else $error("lit count above pixel count");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!ovalid_q || out_ready))
		else $error("output word overwritten");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (dcnt_q != '0))
		else $error("divide step past the last bit");

	a_idx_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.idx_last) |=> (idx_q == '0))
		else $error("pixel counter did not wrap after refresh");

endmodule

// ===== rtl/led_bar_level_meter_peak_decay_top.sv =====
// Top level of the LED bar level meter with peak hold and decay.
// A tick word that drops a pixel, or a qualifying sample with level_step zero that raises
// the bar, goes from idle straight to EMIT; other qualifying samples first run a 10-step divide.
// No new input word is taken until the refresh is out; a refresh puts out PIXEL_COUNT words,
// one per cycle under no back pressure.
// Reset (arst_n low, asynchronous): bar dark, timer cleared, registers at defaults.
`timescale 1ns / 1ps

module led_bar_level_meter_peak_decay_top
	import lbm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Configuration write port
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// Input words
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // [9:0] sample, rest zero
	input  logic              s_tuser,   // [0] action: 0 sample, 1 microsecond tick
	// Pixel words
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,   // [4:0] pixel_index, [12:5] red, [20:13] green,
	                                     // [26:21] lit_count, rest zero
	output logic              m_tlast    // last pixel of a refresh
);

	lbm_cmd_t         cmd;
	lbm_sts_t         sts;
	logic [IDX_W-1:0] o_idx;
	logic [COL_W-1:0] o_red;
	logic [COL_W-1:0] o_green;
	logic [LIT_W-1:0] o_lit;

	// Sequencer: accepts words in idle, runs the divider, paces the refresh
	lbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_action(s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Registers, divider, bar/timer state and the output word register
	lbm_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_sample(s_tdata[SMP_W-1:0]),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_idx  (o_idx),
		.out_red  (o_red),
		.out_green(o_green),
		.out_lit  (o_lit),
		.out_last (m_tlast)
	);

	// Pack the pixel word, low field first, zero fill to 32 bits
	assign m_tdata = {5'd0, o_lit, o_green, o_red, o_idx};

endmodule

// ===== dv/led_bar_level_meter_peak_decay_top_tb.sv =====
// Self-checking testbench for the LED bar level meter with peak hold and decay.
// Drives sample and tick words, predicts every pixel word, checks them in order.
// Depends on lbm_pkg and led_bar_level_meter_peak_decay_top.
`timescale 1ns / 1ps

module led_bar_level_meter_peak_decay_top_tb;
	import lbm_pkg::*;

	typedef struct packed {
		logic             act;
		logic [SMP_W-1:0] smp;
	} meter_in_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [LIT_W-1:0] lit;
		logic             tail;
	} pixel_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;
	logic              m_tlast;

	led_bar_level_meter_peak_decay_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// Words waiting to be sent and pixel words still owed by the block
	meter_in_t   stim_q[$];
	pixel_word_t pixel_q[$];

	// Predicted meter state and register copies
	logic [LIT_W-1:0]   lit_now = '0;
	logic [TIMER_W-1:0] hold_count = '0;
	logic [SMP_W-1:0]   thr_reg = THRESHOLD_RST;
	logic [STEP_W-1:0]  step_reg = LEVEL_STEP_RST;
	logic [HOLD_W-1:0]  hold_reg = HOLD_TICKS_RST;

	bit calm = 1'b0;     // no idling on either side while set
	bit in_fire = 1'b0;  // input word taken at the last rising edge
	int fails = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [COL_W-1:0] gradient_red(input int pos);
		int v;
		v = (3 * (255 / PIXEL_COUNT) * (pos + 1) + 1) / 2;
		return (v > 255) ? COL_W'(255) : COL_W'(v);
	endfunction

	// One refresh: a word per pixel, pixel 0 first
	task automatic push_refresh();
		pixel_word_t w;
		for (int i = 0; i < PIXEL_COUNT; i++) begin
			w.idx   = IDX_W'(i);
			w.red   = (i < lit_now) ? gradient_red(i) : '0;
			w.green = (i < lit_now) ? COL_W'(255 - int'(w.red)) : '0;
			w.lit   = lit_now;
			w.tail  = (i == PIXEL_COUNT - 1);
			pixel_q.push_back(w);
		end
	endtask

	task automatic advance_meter(input logic act, input logic [SMP_W-1:0] smp);
		int count;
		bit show;
		show = 1'b0;
		if (act == ACT_SAMPLE) begin
			if (smp > thr_reg) begin
				if (step_reg == 0)
					count = PIXEL_COUNT;
				else
					count = (int'(smp) - int'(thr_reg)) / int'(step_reg) + 2;
				if (count > PIXEL_COUNT)
					count = PIXEL_COUNT;
				// a qualifying sample restarts the hold even when it is lower
				hold_count = '0;
				if (count >= int'(lit_now)) begin
					lit_now = LIT_W'(count);
					show = 1'b1;
				end
			end
		end else begin
			if (hold_count != TIMER_MAX)
				hold_count = hold_count + 1'b1;
			if (lit_now != 0 && hold_count > hold_reg) begin
				lit_now = lit_now - 1'b1;
				hold_count = '0;
				show = 1'b1;
			end
		end
		if (show)
			push_refresh();
	endtask

	// Driver: move on once the current word is taken, idle now and then
	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 8);
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_fire) begin
			if (stim_q.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
				s_tuser  <= stim_q[0].act;
				s_tdata  <= {6'b0, stim_q[0].smp};
				s_tvalid <= 1'b1;
				void'(stim_q.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: predict on every accepted input word, check every pixel word
	always @(posedge clk) begin
		in_fire = arst_n && s_tvalid && s_tready;
		if (in_fire)
			advance_meter(s_tuser, s_tdata[SMP_W-1:0]);
		if (arst_n && m_tvalid && m_tready) begin
			if (pixel_q.size() == 0) begin
				if (fails < 10)
					$display("unexpected pixel word: tdata %h tlast %b", m_tdata, m_tlast);
				fails++;
			end else begin
				if (m_tdata[4:0] !== pixel_q[0].idx || m_tdata[12:5] !== pixel_q[0].red ||
				    m_tdata[20:13] !== pixel_q[0].green || m_tdata[26:21] !== pixel_q[0].lit ||
				    m_tdata[31:27] !== 5'd0 || m_tlast !== pixel_q[0].tail) begin
					if (fails < 10)
						$display("pixel word mismatch: expected idx %0d red %0d green %0d lit %0d last %b, got idx %0d red %0d green %0d lit %0d pad %h last %b",
							pixel_q[0].idx, pixel_q[0].red, pixel_q[0].green, pixel_q[0].lit,
							pixel_q[0].tail, m_tdata[4:0], m_tdata[12:5], m_tdata[20:13],
							m_tdata[26:21], m_tdata[31:27], m_tlast);
					fails++;
				end
				void'(pixel_q.pop_front());
			end
		end
	end

	task automatic queue_sample(input int smp);
		meter_in_t w;
		w.act = ACT_SAMPLE;
		w.smp = SMP_W'(smp);
		stim_q.push_back(w);
	endtask

	// The sample field of a tick is ignored, so fill it with noise
	task automatic queue_tick();
		meter_in_t w;
		w.act = ACT_TICK;
		w.smp = SMP_W'($urandom_range(1023));
		stim_q.push_back(w);
	endtask

	// Wait until every word is sent and answered, then let a divide finish
	task automatic wait_quiet();
		do
			@(posedge clk);
		while (stim_q.size() != 0 || s_tvalid || pixel_q.size() != 0);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = CFG_W'(value);
		case (idx)
			REG_THRESHOLD:  thr_reg  = SMP_W'(value);
			REG_LEVEL_STEP: step_reg = STEP_W'(value);
			REG_HOLD_TICKS: hold_reg = HOLD_W'(value);
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic load_setting(input int unsigned thr, input int unsigned step,
	                            input int unsigned hold);
		wait_quiet();
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_LEVEL_STEP, step);
		write_reg(REG_HOLD_TICKS, hold);
	endtask

	// Random words for one setting: ticks, alone or in runs long enough to expire a hold
	// under 10, and samples, mostly above threshold
	task automatic queue_random(input int n);
		int run;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 12) begin
				run = (hold_reg < 10) ? int'(hold_reg) + 2 : 3;
				for (int j = 0; j < run; j++)
					queue_tick();
				k += run - 1;
			end else if ($urandom_range(99) < 50) begin
				queue_tick();
			end else if (thr_reg < 1023 && $urandom_range(99) < 75) begin
				queue_sample($urandom_range(1023, int'(thr_reg) + 1));
			end else begin
				queue_sample($urandom_range(1023));
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset setting: below, at and just over threshold, full scale,
		// a lower sample that only restarts the hold, a tick far from expiry and another such sample
		queue_sample(0);
		queue_sample(650);
		queue_sample(651);
		queue_sample(1023);
		queue_sample(651);
		queue_tick();
		queue_sample(680);

		// Zero step lights everything; zero hold decays a pixel per tick down to dark
		load_setting(0, 0, 0);
		queue_sample(1);
		repeat (8) queue_tick();

		// Top threshold: nothing qualifies; longest hold
		load_setting(1023, 1023, 24'hFFFFFF);
		queue_sample(1023);
		queue_tick();

		load_setting(1022, 1, 1);
		queue_sample(1023);
		queue_tick();
		queue_tick();
		queue_sample(1023);

		load_setting(0, 1023, 2);
		queue_sample(1023);
		queue_sample(10'h2AA);

		// Random settings, about 80 words each
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: load_setting($urandom_range(800, 200), $urandom_range(100, 1),
				                $urandom_range(8));
				1: load_setting(0, 1, 0);
				2: load_setting($urandom_range(1000), 0, $urandom_range(5));
				3: load_setting($urandom_range(900), $urandom_range(1023, 1), 3);
				4: load_setting(1000, 7, 10);
				default: load_setting($urandom_range(1023), $urandom_range(1023),
				                      $urandom_range(31));
			endcase
			calm = (p == 3);
			if (p == 2) begin
				// hold back the sender until the block has answered everything
				queue_random(40);
				wait_quiet();
				queue_random(40);
			end else begin
				queue_random(80);
			end
		end

		wait_quiet();
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lbm_pkg.sv
rtl/lbm_ctrl.sv
rtl/lbm_dpath.sv
rtl/led_bar_level_meter_peak_decay_top.sv
dv/led_bar_level_meter_peak_decay_top_tb.sv
